// ===== src/assert_macros.svh =====
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CLCD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CLCD_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define CLCD_ASSERT(label, clk, rst_n, prop)
`define CLCD_ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

// ===== src/clcd_pkg.sv =====
package clcd_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int COL_W   = $clog2(COLUMNS + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_LINE2 = 8'hC0;

  localparam logic [7:0] INIT_SEQ [8] = '{
    8'h39, 8'h14, 8'h73, 8'h56, 8'h6C, 8'h38, 8'h01, 8'h0C
  };

  typedef enum logic [2:0] {
    FN_INIT    = 3'd0,
    FN_PUTCHAR = 3'd1,
    FN_NEWLINE = 3'd2,
    FN_CLEAR   = 3'd3,
    FN_SETCUR  = 3'd4,
    FN_GLYPH   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    BURST_INIT   = 2'd0,
    BURST_SINGLE = 2'd1,
    BURST_PAIR   = 2'd2,
    BURST_GLYPH  = 2'd3
  } burst_kind_t;

  typedef struct packed {
    burst_kind_t kind;
    logic        data_flag;
    logic [7:0]  pre_byte;
    logic [7:0]  body_byte;
    logic [63:0] rows;
  } burst_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

endpackage

// ===== src/clcd_if.sv =====
interface clcd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  char_code;
  logic [1:0]  row_request;
  logic [4:0]  column_request;
  logic [2:0]  glyph_slot;
  logic [63:0] glyph_rows;

  modport source (
    output valid, func, char_code, row_request, column_request, glyph_slot, glyph_rows,
    input  ready
  );
  modport sink (
    input  valid, func, char_code, row_request, column_request, glyph_slot, glyph_rows,
    output ready
  );
endinterface

interface clcd_wr_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, is_data, bus_byte, last, input ready);
  modport sink (input valid, is_data, bus_byte, last, output ready);
endinterface

// ===== src/clcd_front.sv =====
module clcd_front
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  clcd_req_if.sink  in_req,
  input  q_status_t q_stat,
  output logic      push,
  output burst_t    push_burst
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_r, row_nxt;
  logic             accept;
  logic             last_row;
  logic             set_ok;
  logic [7:0]       nl_byte;
  logic             nl_row;
  burst_t           b;
  logic             emit;

  assign in_req.ready = !q_stat.full;
  assign accept       = in_req.valid && in_req.ready;

  assign last_row = (int'(row_r) + 1) >= ROWS;
  assign nl_byte  = last_row ? CMD_CLEAR : CMD_LINE2;
  assign nl_row   = last_row ? 1'b0 : ~row_r;
  assign set_ok   = (int'(in_req.column_request) <= COLUMNS) &&
                    (int'(in_req.row_request) < ROWS);

  always_comb begin
    b           = '0;
    b.rows      = in_req.glyph_rows;
    emit        = 1'b0;
    col_nxt     = col_r;
    row_nxt     = row_r;
    case (func_t'(in_req.func))
      FN_INIT: begin
        b.kind  = BURST_INIT;
        emit    = 1'b1;
        col_nxt = '0;
        row_nxt = 1'b0;
      end
      FN_PUTCHAR: begin
        emit        = 1'b1;
        b.data_flag = 1'b1;
        b.body_byte = in_req.char_code;
        if (int'(col_r) >= COLUMNS) begin
          b.kind     = BURST_PAIR;
          b.pre_byte = nl_byte;
          row_nxt    = nl_row;
          col_nxt    = COL_W'(1);
        end else begin
          b.kind  = BURST_SINGLE;
          col_nxt = col_r + COL_W'(1);
        end
      end
      FN_NEWLINE: begin
        b.kind      = BURST_SINGLE;
        b.body_byte = nl_byte;
        emit        = 1'b1;
        col_nxt     = '0;
        row_nxt     = nl_row;
      end
      FN_CLEAR: begin
        b.kind      = BURST_SINGLE;
        b.body_byte = CMD_CLEAR;
        emit        = 1'b1;
        col_nxt     = '0;
        row_nxt     = 1'b0;
      end
      FN_SETCUR: begin
        if (set_ok) begin
          b.kind      = BURST_SINGLE;
          b.body_byte = {1'b1, in_req.row_request[0], 1'b0, in_req.column_request};
          emit        = 1'b1;
          col_nxt     = COL_W'(in_req.column_request);
          row_nxt     = in_req.row_request[0];
        end
      end
      FN_GLYPH: begin
        b.kind      = BURST_GLYPH;
        b.body_byte = {2'b01, in_req.glyph_slot, 3'b000};
        emit        = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push       = accept && emit;
  assign push_burst = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/clcd_queue.sv =====
module clcd_queue
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  burst_t    push_burst,
  input  logic      pop,
  output q_status_t q_stat,
  output burst_t    head
);

  burst_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign q_stat.full       = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.head_valid = (count_r != '0);
  assign head              = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== src/clcd_back.sv =====
`include "assert_macros.svh"

module clcd_back
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_stat,
  input  burst_t     head,
  output logic       pop,
  clcd_wr_if.source  out_wr
);

  logic [3:0] idx_r;
  logic       out_valid_r;
  logic       is_data_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       wr_is_data;
  logic [7:0] wr_byte;
  logic       wr_last;
  logic [2:0] row_sel;

  assign row_sel = 3'(idx_r - 4'd1);

  always_comb begin
    wr_is_data = 1'b0;
    wr_byte    = head.body_byte;
    wr_last    = 1'b1;
    case (head.kind)
      BURST_INIT: begin
        wr_byte = INIT_SEQ[idx_r[2:0]];
        wr_last = (idx_r == 4'd7);
      end
      BURST_SINGLE: begin
        wr_is_data = head.data_flag;
      end
      BURST_PAIR: begin
        if (idx_r == 4'd0) begin
          wr_byte = head.pre_byte;
          wr_last = 1'b0;
        end else begin
          wr_is_data = 1'b1;
        end
      end
      BURST_GLYPH: begin
        if (idx_r == 4'd0) begin
          wr_last = 1'b0;
        end else begin
          wr_is_data = 1'b1;
          wr_byte    = head.rows[{row_sel, 3'b000} +: 8];
          wr_last    = (idx_r == 4'd8);
        end
      end
      default: begin
        wr_last = 1'b1;
      end
    endcase
  end

  assign load = q_stat.head_valid && (!out_valid_r || out_wr.ready);
  assign pop  = load && wr_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= wr_last ? 4'd0 : idx_r + 4'd1;
      end else if (out_wr.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_data_r <= wr_is_data;
      byte_r    <= wr_byte;
      last_r    <= wr_last;
    end
  end

  assign out_wr.valid    = out_valid_r;
  assign out_wr.is_data  = is_data_r;
  assign out_wr.bus_byte = byte_r;
  assign out_wr.last     = last_r;

  `CLCD_ASSERT(a_burst_contiguous, clk, rst_n, out_valid_r && out_wr.ready && !last_r |=> out_valid_r)
  `CLCD_ASSERT_NEVER(a_idx_range, clk, rst_n, idx_r > 4'd8)
  `CLCD_ASSERT(a_single_idx, clk, rst_n, q_stat.head_valid && head.kind == BURST_SINGLE |-> idx_r == 4'd0)
  `CLCD_ASSERT(a_pop_needs_head, clk, rst_n, pop |-> q_stat.head_valid)

endmodule

// ===== src/char_lcd_text_console.sv =====
// Text console sequencer for a character LCD. Requests (init, put char, newline, clear,
// set cursor, load glyph) are taken one per cycle while the two-entry request queue has
// room; the cursor is tracked at acceptance and each request becomes a burst of
// controller writes, each tagged instruction or data, with last set on its final write.
// Writes leave through a registered output, one per cycle while the port is ready:
// put char gives one or two writes (two when the line is full and the cursor wraps
// first), newline, clear and set cursor one, init eight and load glyph nine. The output
// write port sets the sustained rate. An out-of-range set cursor or an unused function
// code is accepted and gives no write.
module char_lcd_text_console
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  clcd_req_if.sink  in_req,
  clcd_wr_if.source out_wr
);

  q_status_t q_stat;
  logic      push;
  burst_t    push_burst;
  logic      pop;
  burst_t    head;

  clcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .q_stat     (q_stat),
    .push       (push),
    .push_burst (push_burst)
  );

  clcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .q_stat     (q_stat),
    .head       (head)
  );

  clcd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_wr (out_wr)
  );

endmodule
